>>> rtl/dns_rtt_histogram_top_assert.svh
// assertion macros for the dns round-trip histogram
`ifndef DNS_RTT_HISTOGRAM_TOP_ASSERT_SVH
`define DNS_RTT_HISTOGRAM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DRH_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("dns rtt histogram check failed");

`define DRH_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("dns rtt histogram check failed");

`else

`define DRH_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define DRH_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

>>> rtl/dnsrtt_pkg.sv
package dnsrtt_pkg;

	localparam int ID_BITS_DEF    = 16;
	localparam int COUNT_BITS_DEF = 32;

	localparam int NUM_LIMITS  = 5;
	localparam int NUM_BUCKETS = NUM_LIMITS + 1;
	localparam int LIMIT_W     = 22;
	localparam int BUCKET_W    = 3;
	localparam int ID_W        = 16;
	localparam int SEC_W       = 32;
	localparam int USEC_W      = 20;
	localparam int RTT_W       = 32;
	localparam int OUT_CNT_W   = 32;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

	typedef logic [NUM_LIMITS-1:0][LIMIT_W-1:0] limits_t;

	localparam limits_t LIMIT_RESET = {
		LIMIT_W'(1600000),
		LIMIT_W'(800000),
		LIMIT_W'(500000),
		LIMIT_W'(100000),
		LIMIT_W'(10000)
	};

	typedef struct packed {
		logic              is_response;
		logic [ID_W-1:0]   query_id;
		logic [SEC_W-1:0]  time_sec;
		logic [USEC_W-1:0] time_usec;
	} item_t;

	typedef struct packed {
		logic                 was_response;
		logic                 matched;
		logic [BUCKET_W-1:0]  bucket;
		logic [RTT_W-1:0]     rtt_us;
		logic [OUT_CNT_W-1:0] bucket_total;
		logic [OUT_CNT_W-1:0] query_total;
		logic [OUT_CNT_W-1:0] response_total;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic              resp;
		logic              hit;
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
		logic [SEC_W-1:0]  stamp_sec;
		logic [USEC_W-1:0] stamp_usec;
	} lookup_t;

	typedef struct packed {
		logic                valid;
		logic                resp;
		logic                hit;
		logic [BUCKET_W-1:0] bucket;
		logic [RTT_W-1:0]    rtt;
	} bin_t;

endpackage

>>> rtl/dnsrtt_cfg.sv
module dnsrtt_cfg import dnsrtt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output limits_t               limits
);

	logic [REG_IDX_W-1:0] idx;
	logic                 in_range;
	logic                 wr;
	limits_t              limits_q;

	assign idx      = paddr[APB_ADDR_W-1:2];
	assign in_range = idx < REG_IDX_W'(NUM_LIMITS);
	assign wr       = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign limits   = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= LIMIT_RESET;
		end else if (wr && in_range) begin
			limits_q[idx] <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (in_range) begin
			prdata = APB_DATA_W'(limits_q[idx]);
		end
	end

endmodule

>>> rtl/dnsrtt_table.sv
module dnsrtt_table import dnsrtt_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  item_t   item,
	output logic    clearing,
	output lookup_t look
);

	localparam int ENTRY_W = 1 + SEC_W + USEC_W;

	// entry: pending flag, stamp seconds, stamp microseconds
	logic [ENTRY_W-1:0] mem_q [2**ID_BITS];
	logic [ENTRY_W-1:0] rd_q;

	logic               clr_q;
	logic [ID_BITS-1:0] clr_addr_q;

	logic               valid_s1;
	logic               resp_s1;
	logic [ID_BITS-1:0] slot_s1;
	logic [SEC_W-1:0]   sec_s1;
	logic [USEC_W-1:0]  usec_s1;

	logic               pend;
	logic               wr_en;
	logic [ID_BITS-1:0] wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + ID_BITS'(1);
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1 <= item.is_response;
			slot_s1 <= item.query_id[ID_BITS-1:0];
			sec_s1  <= item.time_sec;
			usec_s1 <= item.time_usec;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_q <= mem_q[item.query_id[ID_BITS-1:0]];
		end
	end

	// write-back in the cycle after the read, next item only after that
	always_comb begin
		pend    = rd_q[ENTRY_W-1];
		wr_en   = clr_q || (valid_s1 && (!resp_s1 || pend));
		wr_addr = clr_q ? clr_addr_q : slot_s1;
		if (clr_q) begin
			wr_data = '0;
		end else if (resp_s1) begin
			wr_data = {1'b0, rd_q[ENTRY_W-2:0]};
		end else begin
			wr_data = {1'b1, sec_s1, usec_s1};
		end
	end

	assign clearing        = clr_q;
	assign look.valid      = valid_s1;
	assign look.resp       = resp_s1;
	assign look.hit        = resp_s1 && pend;
	assign look.sec        = sec_s1;
	assign look.usec       = usec_s1;
	assign look.stamp_sec  = rd_q[ENTRY_W-2 -: SEC_W];
	assign look.stamp_usec = rd_q[USEC_W-1:0];

endmodule

>>> rtl/dnsrtt_rtt.sv
module dnsrtt_rtt import dnsrtt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  lookup_t look,
	input  limits_t limits,
	output bin_t    bin
);

	localparam int PROD_W = SEC_W + 1 + USEC_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [SEC_W:0]    sdiff;
	logic signed [USEC_W:0]   udiff;
	logic signed [PROD_W-1:0] prod;

	logic                     valid_s2;
	logic                     resp_s2;
	logic                     hit_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [USEC_W:0]   udiff_s2;

	logic signed [SUM_W-1:0]  sum;
	logic [RTT_W-1:0]         rtt_c;

	logic                     valid_s3;
	logic                     resp_s3;
	logic                     hit_s3;
	logic [RTT_W-1:0]         rtt_s3;

	logic [BUCKET_W-1:0]      bucket_c;

	logic                     valid_s4;
	logic                     resp_s4;
	logic                     hit_s4;
	logic [RTT_W-1:0]         rtt_s4;
	logic [BUCKET_W-1:0]      bucket_s4;

	// whole seconds scaled to microseconds
	always_comb begin
		sdiff = $signed({1'b0, look.sec}) - $signed({1'b0, look.stamp_sec});
		udiff = $signed({1'b0, look.usec}) - $signed({1'b0, look.stamp_usec});
		prod  = PROD_W'(sdiff) * PROD_W'($signed({1'b0, USEC_PER_SEC}));
	end

	// clamp below zero and above the 32-bit range; zero when not a hit
	always_comb begin
		sum = SUM_W'(prod_s2) + SUM_W'(udiff_s2);
		if (!hit_s2 || sum[SUM_W-1]) begin
			rtt_c = '0;
		end else if (|sum[SUM_W-2:RTT_W]) begin
			rtt_c = '1;
		end else begin
			rtt_c = sum[RTT_W-1:0];
		end
	end

	// first limit strictly above the time wins; bucket 0 when not a hit
	always_comb begin
		bucket_c = BUCKET_W'(NUM_LIMITS);
		for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
			if (rtt_s3 < RTT_W'(limits[i])) begin
				bucket_c = BUCKET_W'(i);
			end
		end
		if (!hit_s3) begin
			bucket_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= look.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		resp_s2   <= look.resp;
		hit_s2    <= look.hit;
		prod_s2   <= prod;
		udiff_s2  <= udiff;
		resp_s3   <= resp_s2;
		hit_s3    <= hit_s2;
		rtt_s3    <= rtt_c;
		resp_s4   <= resp_s3;
		hit_s4    <= hit_s3;
		rtt_s4    <= rtt_s3;
		bucket_s4 <= bucket_c;
	end

	assign bin.valid  = valid_s4;
	assign bin.resp   = resp_s4;
	assign bin.hit    = hit_s4;
	assign bin.bucket = bucket_s4;
	assign bin.rtt    = rtt_s4;

endmodule

>>> rtl/dnsrtt_count.sv
module dnsrtt_count import dnsrtt_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  bin_t    bin,
	output logic    done,
	output result_t result
);

	logic [COUNT_BITS-1:0] cnt_q [NUM_BUCKETS];
	logic [COUNT_BITS-1:0] query_q;
	logic [COUNT_BITS-1:0] resp_q;

	logic [COUNT_BITS-1:0] bucket_next;
	logic [COUNT_BITS-1:0] query_next;
	logic [COUNT_BITS-1:0] resp_next;

	logic    done_q;
	result_t result_q;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [OUT_CNT_W-1:0] low_word(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[OUT_CNT_W-1:0];
	endfunction

	always_comb begin
		bucket_next = sat_inc(cnt_q[bin.bucket]);
		query_next  = bin.resp ? query_q : sat_inc(query_q);
		resp_next   = bin.resp ? sat_inc(resp_q) : resp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '{default: '0};
			query_q <= '0;
			resp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= bin.valid;
			if (bin.valid) begin
				query_q <= query_next;
				resp_q  <= resp_next;
				if (bin.hit) begin
					cnt_q[bin.bucket] <= bucket_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bin.valid) begin
			result_q.was_response   <= bin.resp;
			result_q.matched        <= bin.hit;
			result_q.bucket         <= bin.bucket;
			result_q.rtt_us         <= bin.rtt;
			result_q.bucket_total   <= bin.hit ? low_word(bucket_next) : '0;
			result_q.query_total    <= low_word(query_next);
			result_q.response_total <= low_word(resp_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/dns_rtt_histogram_top.sv
// done rises once a taken start has passed the table, rtt pipeline and count registers
// busy covers the table read then write-back; the next message is taken after that write-back
// the receiver cannot stall; each result shows for one cycle only
// reset: limits return to defaults, counters clear, then a clearing pass
// over the id table holds busy high until every entry is cleared
`include "dns_rtt_histogram_top_assert.svh"

module dns_rtt_histogram_top import dnsrtt_pkg::*; #(
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	limits_t limits;
	lookup_t look;
	bin_t    bin;
	logic    clearing;
	logic    accept;

	assign busy   = clearing || look.valid;
	assign accept = start && !busy;

	dnsrtt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	dnsrtt_table #(
		.ID_BITS (ID_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.clearing (clearing),
		.look     (look)
	);

	dnsrtt_rtt u_rtt (
		.clk    (clk),
		.arst_n (arst_n),
		.look   (look),
		.limits (limits),
		.bin    (bin)
	);

	dnsrtt_count #(
		.COUNT_BITS (COUNT_BITS)
	) u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.bin    (bin),
		.done   (done),
		.result (result)
	);

	`DRH_ASSERT_IMP(a_fixed_latency, clk, arst_n, 1'b1, done == $past(accept, 5))
	`DRH_ASSERT_NXT(a_table_interlock, clk, arst_n, accept, busy)
	`DRH_ASSERT_IMP(a_unmatched_zero, clk, arst_n, done && !result.matched, result.bucket == '0 && result.rtt_us == '0 && result.bucket_total == '0)
	`DRH_ASSERT_IMP(a_match_on_response, clk, arst_n, done && result.matched, result.was_response && result.bucket <= BUCKET_W'(NUM_LIMITS))

endmodule
